// File: rtl/core/lesf_pkg.sv
// Shared widths, register indexes and defaults for the largest empty square finder.
package lesf_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int SIZE_W    = 11;
  localparam int POS_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 11'd1024;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [POS_W-1:0]  pos_t;

endpackage

// File: rtl/core/largest_empty_square_finder.sv
// Largest empty square finder: raster cell stream in, one square per map out.
//
// Cells enter on the input channel (in_valid, in_stall, cell_free) in raster
// order, one request per cell, 1 = free, 0 = obstacle. The map dimensions are
// set through the configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data): index 0 is map_width, index 1 is map_height; a value of 0 acts
// as 1 and a value above the column or row limit acts as that limit.
// After the last cell of a map one request leaves on the output channel
// (out_valid, out_stall, best_size, best_row, best_col): the side of the
// largest empty square and its top-left corner, smallest row then smallest
// column on ties, size 0 and corner 0 when no cell is free.
// Throughput is one cell per cycle while in_stall is low: the line buffer of
// the previous row is a two-port memory that takes one read and one write
// each cycle. out_valid rises as the last cell fires from the compute stage.
// While the output holds a result under out_stall, cells keep entering until
// the next final cell of a map reaches the compute stage; in_stall then rises.
// Reset returns the counters, the running best and the map sizes to their
// defaults (1024 by 1024); the line buffer needs no clearing pass.
module largest_empty_square_finder #(
  parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lesf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lesf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cell_free,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lesf_pkg::size_t                best_size,
  output lesf_pkg::pos_t                 best_row,
  output lesf_pkg::pos_t                 best_col
);
  import lesf_pkg::*;

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int RCW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          accept;
  logic          last_col;
  logic          last_row;

  logic          b_valid;
  logic          b_free;
  logic          b_last;
  logic          b_fwd;
  logic [CW-1:0] b_col;
  logic [RW-1:0] b_row;
  logic          b_fire;

  size_t         line_buf [MAX_COLS];
  size_t         rdata;

  size_t left_size;
  size_t diagonal_size;
  size_t best_size_so_far;
  pos_t  best_row_so_far;
  pos_t  best_col_so_far;

  size_t up;
  size_t lf;
  size_t dg;
  size_t min_a;
  size_t min_b;
  size_t size;
  logic  better;
  pos_t  corner_row;
  pos_t  corner_col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_WIDTH_RST;
      map_height <= MAP_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign b_fire   = b_valid && !(b_last && out_valid && out_stall);
  assign in_stall = b_valid && !b_fire;
  assign accept   = in_valid && !in_stall;

  assign last_col = (CCW'(col) + CCW'(1) >= CCW'(map_width)) || (col == CW'(MAX_COLS - 1));
  assign last_row = (RCW'(row) + RCW'(1) >= RCW'(map_height)) || (row == RW'(MAX_ROWS - 1));

  // advance the raster position on each accepted cell
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept || (b_valid && !b_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_free <= cell_free;
      b_col  <= col;
      b_row  <= row;
      b_last <= last_col && last_row;
      b_fwd  <= b_fire && (b_col == col);
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      line_buf[b_col] <= size;
    end
    if (accept) begin
      rdata <= line_buf[col];
    end
  end

  always_comb begin
    up    = (b_row != '0) ? (b_fwd ? left_size : rdata) : '0;
    lf    = (b_col != '0) ? left_size : '0;
    dg    = (b_row != '0 && b_col != '0) ? diagonal_size : '0;
    min_a = (lf < up) ? lf : up;
    min_b = (dg < min_a) ? dg : min_a;
    if (!b_free) begin
      size = '0;
    end else if (min_b == SIZE_SAT) begin
      size = SIZE_SAT;
    end else begin
      size = min_b + SIZE_W'(1);
    end
    better     = size > best_size_so_far;
    corner_row = POS_W'(b_row) + POS_W'(1) - size[POS_W-1:0];
    corner_col = POS_W'(b_col) + POS_W'(1) - size[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size        <= '0;
      diagonal_size    <= '0;
      best_size_so_far <= '0;
      best_row_so_far  <= '0;
      best_col_so_far  <= '0;
    end else if (b_fire) begin
      if (b_last) begin
        left_size        <= '0;
        diagonal_size    <= '0;
        best_size_so_far <= '0;
        best_row_so_far  <= '0;
        best_col_so_far  <= '0;
      end else begin
        left_size     <= size;
        diagonal_size <= up;
        if (better) begin
          best_size_so_far <= size;
          best_row_so_far  <= corner_row;
          best_col_so_far  <= corner_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire && b_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_last) begin
      best_size <= better ? size : best_size_so_far;
      best_row  <= better ? corner_row : best_row_so_far;
      best_col  <= better ? corner_col : best_col_so_far;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_needs_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> b_valid && b_last && out_valid)
    else $error("input stalled without a blocked final cell");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    b_fire && b_last |=> out_valid)
    else $error("final cell left no result");

  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    b_fire && !b_last |=> best_size_so_far >= $past(size))
    else $error("running best fell below a computed size");

  a_fwd_only_col0: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_fwd |-> b_col == '0)
    else $error("line buffer bypass on a column other than the first");
`endif

endmodule

// File: verif/lesf_square_checker.sv
`timescale 1ns / 1ps
// Checker for the largest empty square finder: tracks each map and compares every square reported.
module lesf_square_checker #(
  parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lesf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lesf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           cell_free,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  lesf_pkg::size_t                best_size,
  input  lesf_pkg::pos_t                 best_row,
  input  lesf_pkg::pos_t                 best_col,
  output int                             mismatches,
  output int                             pending
);
  import lesf_pkg::*;

  typedef struct packed {
    size_t size;
    pos_t  row;
    pos_t  col;
  } square_t;

  square_t          squares_due[$];
  square_t          got_sq;
  square_t          want_sq;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  size_t            upper_sizes [MAX_COLS];
  size_t            left_sz;
  size_t            diag_sz;
  size_t            best_sz;
  pos_t             best_r;
  pos_t             best_c;
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  int               errors;

  initial begin
    errors = 0;
  end

  function automatic int unsigned dim_limit(input logic [CFG_W-1:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  task automatic restart_scan();
    left_sz = '0;
    diag_sz = '0;
    col_cnt = 0;
    row_cnt = 0;
    best_sz = '0;
    best_r  = '0;
    best_c  = '0;
  endtask

  task automatic flag(input string msg);
    if (errors < 10) $display("%t: %s", $realtime, msg);
    errors++;
  endtask

  // grow the square ending at this cell and close the map after its last cell
  task automatic scan_cell(input logic free);
    int unsigned w;
    int unsigned h;
    int unsigned up;
    int unsigned lf;
    int unsigned dg;
    int unsigned lo;
    int unsigned sz;
    square_t     sq;
    w  = dim_limit(width_reg, MAX_COLS);
    h  = dim_limit(height_reg, MAX_ROWS);
    up = (row_cnt > 0) ? upper_sizes[col_cnt % MAX_COLS] : 0;
    lf = (col_cnt > 0) ? left_sz : 0;
    dg = (row_cnt > 0 && col_cnt > 0) ? diag_sz : 0;
    sz = 0;
    if (free) begin
      lo = up;
      if (lf < lo) lo = lf;
      if (dg < lo) lo = dg;
      sz = (lo + 1 > SIZE_SAT) ? SIZE_SAT : lo + 1;
    end
    if (sz > best_sz) begin
      best_sz = size_t'(sz);
      best_r  = pos_t'(row_cnt + 1 - sz);
      best_c  = pos_t'(col_cnt + 1 - sz);
    end
    diag_sz = size_t'(up);
    left_sz = size_t'(sz);
    upper_sizes[col_cnt % MAX_COLS] = size_t'(sz);
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        sq.size = best_sz;
        sq.row  = best_r;
        sq.col  = best_c;
        squares_due.push_back(sq);
        restart_scan();
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = MAP_WIDTH_RST;
      height_reg = MAP_HEIGHT_RST;
      foreach (upper_sizes[i]) upper_sizes[i] = '0;
      restart_scan();
      squares_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got_sq.size = best_size;
        got_sq.row  = best_row;
        got_sq.col  = best_col;
        if (squares_due.size() == 0) begin
          flag($sformatf("unexpected square %0d at (%0d,%0d)", best_size, best_row, best_col));
        end else begin
          want_sq = squares_due.pop_front();
          if (got_sq !== want_sq)
            flag($sformatf("square %0d at (%0d,%0d), expected %0d at (%0d,%0d)",
                           best_size, best_row, best_col,
                           want_sq.size, want_sq.row, want_sq.col));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAP_WIDTH:  width_reg  = cfg_data;
          REG_MAP_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) scan_cell(cell_free);
    end
    mismatches <= errors;
    pending    <= squares_due.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the largest empty square finder testbench: clock, reset, map stimulus and verdict.
module testbench;
  import lesf_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_CELLS = 950;
  localparam int RANDOM_MAPS  = 30;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAP_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cell_free = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  size_t                best_size;
  pos_t                 best_row;
  pos_t                 best_col;
  int                   mismatches;
  int                   pending;
  int                   idle_mode = 0;
  int                   hold_asks = 0;
  int                   hold_seen = 0;
  int                   hold_left = 0;
  int unsigned          random_cells;
  int unsigned          random_maps;

  largest_empty_square_finder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cell_free (cell_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .best_size (best_size),
    .best_row  (best_row),
    .best_col  (best_col)
  );

  lesf_square_checker squares_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_free  (cell_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_size  (best_size),
    .best_row   (best_row),
    .best_col   (best_col),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // hold off for a long stretch when asked, else stall at random (never in idle mode 2)
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < ((idle_mode == 0) ? 45 : (idle_mode == 1) ? 34 : 0);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_cell(input logic free);
    while ($urandom_range(99) < ((idle_mode == 0) ? 34 : (idle_mode == 1) ? 45 : 0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cell_free <= free;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_pattern(input logic [63:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_cell(bits[i]);
  endtask

  task automatic send_map(input int unsigned n, input int unsigned free_pct, input bit last_free);
    for (int unsigned i = 0; i < n; i++)
      send_cell((last_free && i == n - 1) ? 1'b1 : ($urandom_range(99) < free_pct));
  endtask

  // drain every request, then give the block its latency before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned maps;
    int unsigned pct;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(0, 0);
    send_pattern(64'b10, 2);
    settle();
    configure(3, 3);
    send_pattern(64'b111_111_111, 9);
    settle();
    configure(5, 2);
    send_pattern(64'b11011_11011, 10);
    settle();
    configure(4, 1);
    send_pattern(64'b0000, 4);
    settle();

    configure(2, 2);
    hold_asks <= hold_asks + 1;
    for (int i = 0; i < 30; i++) send_map(4, 80, 1'b0);
    settle();

    random_cells = 0;
    random_maps  = 0;
    while (random_cells < RANDOM_CELLS || random_maps < RANDOM_MAPS) begin
      idle_mode <= (random_cells < RANDOM_CELLS / 3) ? 0 :
                   (random_cells < 2 * RANDOM_CELLS / 3) ? 1 : 2;
      if ($urandom_range(3) == 0) begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 16);
      end else begin
        w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      end
      case ($urandom_range(2))
        0:       pct = 50;
        1:       pct = 85;
        default: pct = 97;
      endcase
      configure(w, h);
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      maps = $urandom_range(1, 4);
      for (int unsigned m = 0; m < maps; m++) begin
        send_map(w * h, pct, 1'b0);
        random_cells += w * h;
        random_maps++;
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("largest_empty_square_finder: match");
    else
      $display("largest_empty_square_finder: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("largest_empty_square_finder: mismatch");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lesf_pkg.sv
rtl/core/largest_empty_square_finder.sv
verif/lesf_square_checker.sv
verif/testbench.sv
